FILE: rtl/rfd_pkg.sv
// Shared constants and types of the remote frame deframer.
package rfd_pkg;

  localparam logic [7:0]  HDR0         = 8'hA9;
  localparam logic [7:0]  HDR1         = 8'h53;
  localparam logic [15:0] CRC_POLY_MSB = 16'h1021;
  localparam logic [15:0] CRC_POLY_LSB = 16'h8408;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [10:0] CENTER_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CRC,
    ST_CHECK
  } rfd_state_e;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctrl_t;

endpackage

FILE: rtl/rfd_if.sv
// Channel interfaces of the remote frame deframer: byte input, config write, result.
interface rfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] channel_center;
  modport source (output valid, output channel_center, input ready);
  modport sink (input valid, input channel_center, output ready);
endinterface

interface rfd_res_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [11:0] right_x;
  logic signed [11:0] right_y;
  logic signed [11:0] left_y;
  logic signed [11:0] left_x;
  logic signed [11:0] dial_pos;
  logic [8:0]         buttons;
  logic signed [15:0] mouse_dx;
  logic signed [15:0] mouse_dy;
  logic signed [15:0] mouse_wheel;
  logic [15:0]        keys;
  logic [31:0]        count;
  modport source (output valid, output status, output right_x, output right_y,
                  output left_y, output left_x, output dial_pos, output buttons,
                  output mouse_dx, output mouse_dy, output mouse_wheel, output keys,
                  output count, input ready);
  modport sink (input valid, input status, input right_x, input right_y,
                input left_y, input left_x, input dial_pos, input buttons,
                input mouse_dx, input mouse_dy, input mouse_wheel, input keys,
                input count, output ready);
endinterface

FILE: rtl/rfd_cell.sv
// One byte cell of the frame window chain.
module rfd_cell import rfd_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] nbr_i,
  input  logic [7:0] byte_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    if (ctrl_i.shift) begin
      data_d = nbr_i;
    end else if (ctrl_i.wr) begin
      data_d = byte_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/rfd_crc.sv
// Byte-serial CRC accumulator, normal and reflected CCITT forms side by side.
module rfd_crc import rfd_pkg::*; (
  input  logic        clk_i,
  input  logic        init_i,
  input  logic        en_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_msb_o,
  output logic [15:0] crc_lsb_o
);

  logic [15:0] msb_q, msb_d;
  logic [15:0] lsb_q, lsb_d;

  function automatic logic [15:0] step_msb(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY_MSB) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [15:0] step_lsb(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY_LSB) : {1'b0, r[15:1]};
    end
    return r;
  endfunction

  always_comb begin
    msb_d = msb_q;
    lsb_d = lsb_q;
    if (init_i) begin
      msb_d = CRC_INIT;
      lsb_d = CRC_INIT;
    end else if (en_i) begin
      msb_d = step_msb(msb_q, byte_i);
      lsb_d = step_lsb(lsb_q, byte_i);
    end
  end

  always_ff @(posedge clk_i) begin
    msb_q <= msb_d;
    lsb_q <= lsb_d;
  end

  assign crc_msb_o = msb_q;
  assign crc_lsb_o = lsb_q;

endmodule

FILE: rtl/remote_frame_deframer_unit.sv
// Top level of the remote frame deframer: byte cell chain, CRC unit and sequencer.
//
//   channel  dir  signals                          meaning
//   rx_i     in   valid ready rx_byte              one received byte per transfer
//   cfg_i    in   valid ready channel_center       channel center register write
//   res_o    out  valid ready status..count        one result per checked frame
//
// A byte that does not complete a frame is written into the chain and checked for a
// header; when it breaks a header pair, one byte is also dropped.
// A full frame rotates once around the cell chain to feed the CRC unit and is then
// compared in ST_CHECK; a failed frame then shifts the chain one byte per cycle to
// the next header or down to the last byte.
// Reset clears the fill count, counters, last fields and the center to 1024.
// A result waits in its output register; only a next check stalls on a full one.
module remote_frame_deframer_unit import rfd_pkg::*; #(
  parameter int FRAME_BYTES = 21
) (
  input  logic clk_i,
  input  logic rst_ni,
  rfd_byte_if.sink   rx_i,
  rfd_cfg_if.sink    cfg_i,
  rfd_res_if.source  res_o
);

  localparam int FillW = $clog2(FRAME_BYTES + 1);
  localparam int CntW  = $clog2(FRAME_BYTES);

  rfd_state_e state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]  lo_q, hi_q;
  logic [10:0] center_q;
  logic [31:0] good_q, bad_q;

  logic [7:0] cell_data [FRAME_BYTES];
  logic [8*FRAME_BYTES-1:0] win;
  logic shift, wr_en, crc_init, crc_en, load_good, load_bad;
  logic [15:0] crc_msb, crc_lsb;

  for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
    localparam int Nxt = (k + 1) % FRAME_BYTES;
    cell_ctrl_t ctrl;
    assign ctrl.shift = shift;
    assign ctrl.wr    = wr_en && (fill_q == FillW'(k));
    rfd_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .nbr_i  (cell_data[Nxt]),
      .byte_i (rx_i.rx_byte),
      .data_o (cell_data[k])
    );
    assign win[8*k +: 8] = cell_data[k];
  end

  rfd_crc u_crc (
    .clk_i     (clk_i),
    .init_i    (crc_init),
    .en_i      (crc_en),
    .byte_i    (cell_data[0]),
    .crc_msb_o (crc_msb),
    .crc_lsb_o (crc_lsb)
  );

  logic head_hdr, frame_ok, out_free;
  logic [15:0] le, be;

  assign head_hdr = (cell_data[0] == HDR0) && (cell_data[1] == HDR1);
  assign le       = {hi_q, lo_q};
  assign be       = {lo_q, hi_q};
  assign frame_ok = (crc_msb == le) || (crc_msb == be) || (crc_lsb == le) || (crc_lsb == be);

  // Decoded fields sit at fixed bit positions of the window, LSB first.
  logic signed [11:0] dec_stick [5];
  logic [10:0] raw [5];
  logic [8:0]  dec_buttons;

  assign raw[0] = win[26:16];
  assign raw[1] = win[37:27];
  assign raw[2] = win[48:38];
  assign raw[3] = win[59:49];
  assign raw[4] = win[75:65];

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      dec_stick[k] = $signed({1'b0, raw[k]} - {1'b0, center_q});
    end
  end

  assign dec_buttons = {win[133:132] == 2'b01, win[131:130] == 2'b01,
                        win[129:128] == 2'b01, win[76], win[64], win[63], win[62],
                        win[61:60]};

  logic out_valid_q;
  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    shift     = 1'b0;
    wr_en     = 1'b0;
    crc_init  = 1'b0;
    crc_en    = 1'b0;
    load_good = 1'b0;
    load_bad  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (rx_i.valid) begin
          wr_en   = 1'b1;
          fill_d  = fill_q + 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (fill_q < FillW'(2)) begin
          state_d = ST_IDLE;
        end else if (!head_hdr) begin
          // Dropping one byte at a time stops at the next header or at the last byte.
          shift  = 1'b1;
          fill_d = fill_q - 1'b1;
        end else if (fill_q == FillW'(FRAME_BYTES)) begin
          crc_init = 1'b1;
          cnt_d    = '0;
          state_d  = ST_CRC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CRC: begin
        // A full rotation leaves the window in its original order.
        shift  = 1'b1;
        crc_en = cnt_q < CntW'(FRAME_BYTES - 2);
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntW'(FRAME_BYTES - 1)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (out_free) begin
          if (frame_ok) begin
            load_good = 1'b1;
            fill_d    = '0;
            state_d   = ST_IDLE;
          end else begin
            load_bad = 1'b1;
            shift    = 1'b1;
            fill_d   = fill_q - 1'b1;
            state_d  = ST_SCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CRC && cnt_q == CntW'(FRAME_BYTES - 2)) begin
      lo_q <= cell_data[0];
    end
    if (state_q == ST_CRC && cnt_q == CntW'(FRAME_BYTES - 1)) begin
      hi_q <= cell_data[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CENTER_RESET;
    end else if (cfg_i.valid) begin
      center_q <= cfg_i.channel_center;
    end
  end

  assign cfg_i.ready = 1'b1;
  assign rx_i.ready  = (state_q == ST_IDLE);

  logic signed [11:0] last_stick_q [5];
  logic [8:0]  last_buttons_q;
  logic [15:0] last_dx_q, last_dy_q, last_wheel_q, last_keys_q;
  logic        out_status_q;
  logic [31:0] out_count_q;
  logic signed [11:0] out_stick_q [5];
  logic [8:0]  out_buttons_q;
  logic [15:0] out_dx_q, out_dy_q, out_wheel_q, out_keys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q         <= '0;
      bad_q          <= '0;
      last_buttons_q <= '0;
      last_dx_q      <= '0;
      last_dy_q      <= '0;
      last_wheel_q   <= '0;
      last_keys_q    <= '0;
      out_valid_q    <= 1'b0;
      for (int k = 0; k < 5; k++) begin
        last_stick_q[k] <= '0;
      end
    end else begin
      if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (load_good) begin
        good_q         <= good_q + 32'd1;
        last_buttons_q <= dec_buttons;
        last_dx_q      <= win[95:80];
        last_dy_q      <= win[111:96];
        last_wheel_q   <= win[127:112];
        last_keys_q    <= win[151:136];
        for (int k = 0; k < 5; k++) begin
          last_stick_q[k] <= dec_stick[k];
        end
        out_valid_q <= 1'b1;
      end
      if (load_bad) begin
        bad_q       <= bad_q + 32'd1;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_good) begin
      out_status_q  <= 1'b0;
      out_count_q   <= good_q + 32'd1;
      out_buttons_q <= dec_buttons;
      out_dx_q      <= win[95:80];
      out_dy_q      <= win[111:96];
      out_wheel_q   <= win[127:112];
      out_keys_q    <= win[151:136];
      for (int k = 0; k < 5; k++) begin
        out_stick_q[k] <= dec_stick[k];
      end
    end else if (load_bad) begin
      out_status_q  <= 1'b1;
      out_count_q   <= bad_q + 32'd1;
      out_buttons_q <= last_buttons_q;
      out_dx_q      <= last_dx_q;
      out_dy_q      <= last_dy_q;
      out_wheel_q   <= last_wheel_q;
      out_keys_q    <= last_keys_q;
      for (int k = 0; k < 5; k++) begin
        out_stick_q[k] <= last_stick_q[k];
      end
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.right_x     = out_stick_q[0];
  assign res_o.right_y     = out_stick_q[1];
  assign res_o.left_y      = out_stick_q[2];
  assign res_o.left_x      = out_stick_q[3];
  assign res_o.dial_pos    = out_stick_q[4];
  assign res_o.buttons     = out_buttons_q;
  assign res_o.mouse_dx    = $signed(out_dx_q);
  assign res_o.mouse_dy    = $signed(out_dy_q);
  assign res_o.mouse_wheel = $signed(out_wheel_q);
  assign res_o.keys        = out_keys_q;
  assign res_o.count       = out_count_q;

endmodule

FILE: rtl/rfd_checker.sv
// Port-level assertions for the remote frame deframer, bound to the top level.
module rfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic [31:0] out_count
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_count))
    else $error("stalled result changed");

  a_no_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid))
    else $error("result appeared one cycle after a byte transfer");

  a_check_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result produced while input was open");

endmodule

bind remote_frame_deframer_unit rfd_checker u_rfd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (rx_i.valid),
  .in_ready   (rx_i.ready),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .out_status (res_o.status),
  .out_count  (res_o.count)
);
